[design/nels_pkg.sv]
`default_nettype none

package nels_pkg;

    // Q32.32 one
    localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // Shared unit operations
    localparam logic [1:0] OP_EPROD = 2'd0;  // element product, rescaled to Q32.32
    localparam logic [1:0] OP_QMUL  = 2'd1;  // Q32.32 multiply
    localparam logic [1:0] OP_QDIV  = 2'd2;  // Q32.32 divide

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] res;
    } alu_rsp_t;

    // Magnitude of a two's complement word; the most negative value gives 2^63
    function automatic logic [63:0] magn(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Signed result from magnitude and sign, saturated
    function automatic logic [63:0] sat_from(input logic [63:0] mag, input logic neg,
                                             input logic ovf);
        if (neg)
            return (ovf || mag[63]) ? S64_MIN : (~mag + 64'd1);
        return (ovf || mag[63]) ? S64_MAX : mag;
    endfunction

    // Saturating add or subtract
    function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                               input logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

endpackage

`default_nettype wire

[design/nels_if.sv]
`default_nettype none

interface nels_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               final_row;

    modport source (output valid, output sample, output final_row, input ready);
    modport sink   (input valid, input sample, input final_row, output ready);
endinterface

interface nels_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] coefficient;
    logic        [2:0]  coef_index;
    logic               last_coef;
    logic               singular;

    modport source (output valid, output coefficient, output coef_index,
                    output last_coef, output singular, input ready);
    modport sink   (input valid, input coefficient, input coef_index,
                    input last_coef, input singular, output ready);
endinterface

`default_nettype wire

[design/nels_alu.sv]
`default_nettype none

// Shared multiply / divide unit. Multiply runs four 32x32 partial products;
// divide is restoring, one quotient bit a cycle.
module nels_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nels_pkg::alu_req_t req,
    output nels_pkg::alu_rsp_t      rsp
);

    localparam int SH  = 32 - 2 * FRAC_BITS;
    localparam int SHL = (SH > 0) ? SH : 0;
    localparam int SHR = (SH < 0) ? -SH : 0;
    localparam logic [7:0] DIV_STEPS = 8'd128;
    localparam logic [7:0] MUL_LAST  = 8'd5;
    localparam logic [7:0] PP_COUNT  = 8'd4;

    logic         busy_reg;
    logic         done_reg;
    logic [1:0]   op_reg;
    logic [7:0]   cnt_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   ppsh_reg;
    logic [127:0] num_reg;
    logic [127:0] q_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  res_reg;

    logic         start;
    logic         is_div;
    logic         finish;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp_mul;
    logic [127:0] pp_shift;
    logic [64:0]  rs;
    logic         ge;
    logic [63:0]  rem_next;
    logic [127:0] ep_ext;
    logic [63:0]  ep_res;
    logic [63:0]  mul_res;
    logic [63:0]  div_res;

    assign start  = req.start && !busy_reg;
    assign is_div = (op_reg == nels_pkg::OP_QDIV);
    assign finish = busy_reg && (is_div ? (cnt_reg == DIV_STEPS) : (cnt_reg == MUL_LAST));

    // Partial product select: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_part = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_part = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign pp_mul = a_part * b_part;

    always_comb
    begin
        unique case (ppsh_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd3:    pp_shift = {pp_reg, 64'd0};
            default: pp_shift = {32'd0, pp_reg, 32'd0};
        endcase
    end

    // Restoring divide step
    assign rs       = {rem_reg, num_reg[127]};
    assign ge       = rs[64] || (rs[63:0] >= ub_reg);
    assign rem_next = ge ? (rs[63:0] - ub_reg) : rs[63:0];

    // Result formatting
    assign ep_ext  = ({64'd0, acc_reg[63:0]} << SHL) >> SHR;
    assign ep_res  = nels_pkg::sat_from(ep_ext[63:0], neg_reg, |ep_ext[127:64]);
    assign mul_res = nels_pkg::sat_from(acc_reg[95:32], neg_reg, |acc_reg[127:96]);
    assign div_res = nels_pkg::sat_from(q_reg[63:0], neg_reg, |q_reg[127:64]);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= nels_pkg::OP_EPROD;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= finish;
            if (start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (busy_reg)
                cnt_reg <= cnt_reg + 8'd1;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= nels_pkg::magn(req.a);
            ub_reg  <= nels_pkg::magn(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            acc_reg <= '0;
            num_reg <= {32'd0, nels_pkg::magn(req.a), 32'd0};
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else if (finish)
        begin
            unique case (op_reg)
                nels_pkg::OP_EPROD: res_reg <= ep_res;
                nels_pkg::OP_QDIV:  res_reg <= div_res;
                default:            res_reg <= mul_res;
            endcase
        end
        else if (busy_reg && is_div)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[126:0], ge};
        end
        else if (busy_reg)
        begin
            if (cnt_reg < PP_COUNT)
            begin
                pp_reg   <= pp_mul;
                ppsh_reg <= cnt_reg[1:0];
            end
            if (cnt_reg != 8'd0)
                acc_reg <= acc_reg + pp_shift;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

[design/normal_equation_least_squares.sv]
`default_nettype none

// Channel   Dir  Payload                                           Request
// samples   in   sample[31:0] Q16.16, final_row                    one row element
// coefs     out  coefficient[63:0] Q32.32, coef_index, last_coef,  one weight
//                singular
//
// A target element folds the row into the Gram matrix: COLS*(COLS+1) element
// products on the shared unit. Solve: 2*COLS^2 divides plus 2*COLS^2*(COLS-1)
// and COLS^2 multiplies, all serialized on the one shared multiply/divide unit.
// Reset clears the accumulators through per-entry valid bits; no clearing pass.
// samples.ready is low from a target element until that row is folded in, and
// after a final row until the solve and its output end; coefs stalls hold the
// sequencer in place with the weight in the output register.
module normal_equation_least_squares #(
    parameter int COLS      = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nels_in_if.sink     samples,
    nels_out_if.source  coefs
);

    localparam int IW    = $clog2(COLS);
    localparam int PW    = $clog2(COLS + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic [IW-1:0] LAST = IW'(COLS - 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ACC_XR   = 5'd1;
    localparam logic [4:0] S_ACC_MUL  = 5'd2;
    localparam logic [4:0] S_ACC_WT   = 5'd3;
    localparam logic [4:0] S_ACC_CR   = 5'd4;
    localparam logic [4:0] S_ACC_CRW  = 5'd5;
    localparam logic [4:0] S_INV_INIT = 5'd6;
    localparam logic [4:0] S_PIV_RD   = 5'd7;
    localparam logic [4:0] S_PIV_CMP  = 5'd8;
    localparam logic [4:0] S_PIV_SEL  = 5'd9;
    localparam logic [4:0] S_SWAP     = 5'd10;
    localparam logic [4:0] S_NRM_RD   = 5'd11;
    localparam logic [4:0] S_NRM_GO   = 5'd12;
    localparam logic [4:0] S_NRM_WT   = 5'd13;
    localparam logic [4:0] S_ELM_J    = 5'd14;
    localparam logic [4:0] S_ELM_FRD  = 5'd15;
    localparam logic [4:0] S_ELM_FLT  = 5'd16;
    localparam logic [4:0] S_ELM_ARD  = 5'd17;
    localparam logic [4:0] S_ELM_AGO  = 5'd18;
    localparam logic [4:0] S_ELM_WT   = 5'd19;
    localparam logic [4:0] S_NEXT_I   = 5'd20;
    localparam logic [4:0] S_OUT_R    = 5'd21;
    localparam logic [4:0] S_DOT_RD   = 5'd22;
    localparam logic [4:0] S_DOT_GO   = 5'd23;
    localparam logic [4:0] S_DOT_WT   = 5'd24;
    localparam logic [4:0] S_EMIT     = 5'd25;
    localparam logic [4:0] S_CLEAR    = 5'd26;

    // Control state
    logic [4:0]    state_reg;
    logic [4:0]    state_next;
    logic [PW-1:0] epos_reg;
    logic [IW-1:0] r_reg;
    logic [IW-1:0] c_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic          msel_reg;
    logic          fin_reg;
    logic          sing_reg;
    logic          ov_reg;
    logic [DEPTH-1:0] gvld_reg;
    logic [DEPTH-1:0] ivld_reg;
    logic [63:0]   cross_reg [COLS];

    // Payload
    logic [31:0]   rb_reg [COLS];
    logic [IW-1:0] perm_reg [COLS];
    logic [31:0]   xr_reg;
    logic [31:0]   tgt_reg;
    logic [63:0]   best_mag_reg;
    logic [63:0]   best_val_reg;
    logic [IW-1:0] piv_reg;
    logic [IW-1:0] pi_reg;
    logic [IW-1:0] pj_reg;
    logic [63:0]   f_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   out_coef_reg;
    logic [2:0]    out_idx_reg;
    logic          out_last_reg;
    logic          out_sing_reg;

    // Matrix memories, rows addressed by physical row
    logic [63:0]   gram_mem [DEPTH];
    logic [63:0]   inv_mem [DEPTH];
    logic [63:0]   gram_q_reg;
    logic [63:0]   inv_q_reg;
    logic          gv_q_reg;
    logic          iv_q_reg;
    logic          diag_q_reg;

    logic          in_acc;
    logic          alu_done;
    logic          out_ld;
    logic [IW-1:0] rb_idx;
    logic [IW-1:0] cross_idx;
    logic [IW-1:0] perm_idx;
    logic [31:0]   rb_q;
    logic [63:0]   cross_q;
    logic [IW-1:0] perm_q;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          gram_we;
    logic          inv_we;
    logic [63:0]   wr_data;
    logic [63:0]   gram_eff;
    logic [63:0]   inv_eff;
    logic [63:0]   rd_eff;
    logic [63:0]   piv_mag;

    nels_pkg::alu_req_t alu_req;
    nels_pkg::alu_rsp_t alu_rsp;

    nels_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign in_acc        = samples.valid && samples.ready;
    assign alu_done      = alu_rsp.done;
    assign out_ld        = (state_reg == S_EMIT) && (!ov_reg || coefs.ready);

    // One read index per small array per cycle
    assign rb_idx    = (state_reg == S_ACC_XR) ? r_reg : c_reg;
    assign cross_idx = (state_reg == S_ACC_CRW) ? r_reg : c_reg;
    assign rb_q      = rb_reg[rb_idx];
    assign cross_q   = cross_reg[cross_idx];
    assign perm_q    = perm_reg[perm_idx];

    always_comb
    begin
        unique case (state_reg)
            S_PIV_SEL: perm_idx = piv_reg;
            S_SWAP:    perm_idx = i_reg;
            S_OUT_R:   perm_idx = r_reg;
            default:   perm_idx = j_reg;
        endcase
    end

    // Entries never written read as zero (Gram) or identity (inverse)
    assign gram_eff = gv_q_reg ? gram_q_reg : '0;
    assign inv_eff  = iv_q_reg ? inv_q_reg : (diag_q_reg ? nels_pkg::Q_ONE : '0);
    assign rd_eff   = msel_reg ? inv_eff : gram_eff;
    assign piv_mag  = nels_pkg::magn(gram_eff);

    // Memory read address
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = {pj_reg, c_reg};
        unique case (state_reg)
            S_ACC_MUL: rd_addr = {r_reg, c_reg};
            S_PIV_RD:  rd_addr = {perm_q, i_reg};
            S_NRM_RD:  rd_addr = {pi_reg, c_reg};
            S_ELM_FRD: rd_addr = {pj_reg, i_reg};
            S_ELM_ARD: rd_addr = {pi_reg, c_reg};
            S_ELM_AGO: rd_addr = {pj_reg, c_reg};
            S_DOT_RD:  rd_addr = {pj_reg, c_reg};
            default:   rd_en   = 1'b0;
        endcase
    end

    // Memory write
    always_comb
    begin
        gram_we = 1'b0;
        inv_we  = 1'b0;
        wr_addr = {pj_reg, c_reg};
        wr_data = nels_pkg::sat_addsub(rd_eff, alu_rsp.res, 1'b1);
        unique case (state_reg)
            S_ACC_WT:
            begin
                gram_we = alu_done;
                wr_addr = {r_reg, c_reg};
                wr_data = nels_pkg::sat_addsub(gram_eff, alu_rsp.res, 1'b0);
            end
            S_NRM_WT:
            begin
                gram_we = alu_done && !msel_reg;
                inv_we  = alu_done && msel_reg;
                wr_addr = {pi_reg, c_reg};
                wr_data = alu_rsp.res;
            end
            S_ELM_WT:
            begin
                gram_we = alu_done && !msel_reg;
                inv_we  = alu_done && msel_reg;
            end
            default:
            begin
                gram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (gram_we)
            gram_mem[wr_addr] <= wr_data;
        if (inv_we)
            inv_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            gram_q_reg <= gram_mem[rd_addr];
            inv_q_reg  <= inv_mem[rd_addr];
            gv_q_reg   <= gvld_reg[rd_addr];
            iv_q_reg   <= ivld_reg[rd_addr];
            diag_q_reg <= (rd_addr[AW-1:IW] == rd_addr[IW-1:0]);
        end
    end

    // Shared unit requests
    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = nels_pkg::OP_QMUL;
        alu_req.a     = f_reg;
        alu_req.b     = rd_eff;
        unique case (state_reg)
            S_ACC_MUL:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = nels_pkg::OP_EPROD;
                alu_req.a     = {{32{xr_reg[31]}}, xr_reg};
                alu_req.b     = {{32{rb_q[31]}}, rb_q};
            end
            S_ACC_CR:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = nels_pkg::OP_EPROD;
                alu_req.a     = {{32{xr_reg[31]}}, xr_reg};
                alu_req.b     = {{32{tgt_reg[31]}}, tgt_reg};
            end
            S_NRM_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = nels_pkg::OP_QDIV;
                alu_req.a     = rd_eff;
                alu_req.b     = best_val_reg;
            end
            S_ELM_AGO:
            begin
                alu_req.start = 1'b1;
            end
            S_DOT_GO:
            begin
                alu_req.start = 1'b1;
                alu_req.a     = inv_eff;
                alu_req.b     = cross_q;
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc && (epos_reg == PW'(COLS)))
                    state_next = S_ACC_XR;
            S_ACC_XR:   state_next = S_ACC_MUL;
            S_ACC_MUL:  state_next = S_ACC_WT;
            S_ACC_WT:
                if (alu_done)
                    state_next = (c_reg == LAST) ? S_ACC_CR : S_ACC_MUL;
            S_ACC_CR:   state_next = S_ACC_CRW;
            S_ACC_CRW:
                if (alu_done)
                begin
                    if (r_reg != LAST)
                        state_next = S_ACC_XR;
                    else
                        state_next = fin_reg ? S_INV_INIT : S_IDLE;
                end
            S_INV_INIT: state_next = S_PIV_RD;
            S_PIV_RD:   state_next = S_PIV_CMP;
            S_PIV_CMP:  state_next = (j_reg == LAST) ? S_PIV_SEL : S_PIV_RD;
            S_PIV_SEL:  state_next = (best_val_reg == '0) ? S_OUT_R : S_SWAP;
            S_SWAP:     state_next = S_NRM_RD;
            S_NRM_RD:   state_next = S_NRM_GO;
            S_NRM_GO:   state_next = S_NRM_WT;
            S_NRM_WT:
                if (alu_done)
                    state_next = (c_reg == LAST && msel_reg) ? S_ELM_J : S_NRM_RD;
            S_ELM_J:
                if (j_reg != i_reg)
                    state_next = S_ELM_FRD;
                else if (j_reg == LAST)
                    state_next = S_NEXT_I;
            S_ELM_FRD:  state_next = S_ELM_FLT;
            S_ELM_FLT:  state_next = S_ELM_ARD;
            S_ELM_ARD:  state_next = S_ELM_AGO;
            S_ELM_AGO:  state_next = S_ELM_WT;
            S_ELM_WT:
                if (alu_done)
                begin
                    if (c_reg != LAST || !msel_reg)
                        state_next = S_ELM_ARD;
                    else
                        state_next = (j_reg == LAST) ? S_NEXT_I : S_ELM_J;
                end
            S_NEXT_I:   state_next = (i_reg == LAST) ? S_OUT_R : S_PIV_RD;
            S_OUT_R:    state_next = sing_reg ? S_EMIT : S_DOT_RD;
            S_DOT_RD:   state_next = S_DOT_GO;
            S_DOT_GO:   state_next = S_DOT_WT;
            S_DOT_WT:
                if (alu_done)
                    state_next = (c_reg == LAST) ? S_EMIT : S_DOT_RD;
            S_EMIT:
                if (out_ld)
                    state_next = (r_reg == LAST) ? S_CLEAR : S_OUT_R;
            S_CLEAR:    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            epos_reg  <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            msel_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            sing_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            gvld_reg  <= '0;
            ivld_reg  <= '0;
            for (int k = 0; k < COLS; k++)
                cross_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (gram_we)
                gvld_reg[wr_addr] <= 1'b1;
            if (inv_we)
                ivld_reg[wr_addr] <= 1'b1;

            // output register
            if (out_ld)
                ov_reg <= 1'b1;
            else if (coefs.ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                    begin
                        if (epos_reg == PW'(COLS))
                        begin
                            epos_reg <= '0;
                            fin_reg  <= samples.final_row;
                            r_reg    <= '0;
                        end
                        else
                            epos_reg <= epos_reg + PW'(1);
                    end
                S_ACC_XR:
                    c_reg <= '0;
                S_ACC_WT:
                    if (alu_done)
                        c_reg <= c_reg + IW'(1);
                S_ACC_CRW:
                    if (alu_done)
                    begin
                        cross_reg[r_reg] <= nels_pkg::sat_addsub(cross_q, alu_rsp.res, 1'b0);
                        r_reg            <= r_reg + IW'(1);
                    end
                S_INV_INIT:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    r_reg <= '0;
                end
                S_PIV_CMP:
                    j_reg <= j_reg + IW'(1);
                S_PIV_SEL:
                    if (best_val_reg == '0)
                        sing_reg <= 1'b1;
                S_SWAP:
                begin
                    c_reg    <= '0;
                    msel_reg <= 1'b0;
                end
                S_NRM_WT:
                    if (alu_done)
                    begin
                        if (c_reg == LAST)
                        begin
                            c_reg    <= '0;
                            msel_reg <= !msel_reg;
                            if (msel_reg)
                                j_reg <= '0;
                        end
                        else
                            c_reg <= c_reg + IW'(1);
                    end
                S_ELM_J:
                    if (j_reg == i_reg)
                        j_reg <= j_reg + IW'(1);
                S_ELM_FLT:
                begin
                    c_reg    <= '0;
                    msel_reg <= 1'b0;
                end
                S_ELM_WT:
                    if (alu_done)
                    begin
                        if (c_reg == LAST)
                        begin
                            c_reg    <= '0;
                            msel_reg <= !msel_reg;
                            if (msel_reg)
                                j_reg <= j_reg + IW'(1);
                        end
                        else
                            c_reg <= c_reg + IW'(1);
                    end
                S_NEXT_I:
                begin
                    i_reg <= i_reg + IW'(1);
                    j_reg <= i_reg + IW'(1);
                end
                S_OUT_R:
                begin
                    c_reg    <= '0;
                    msel_reg <= 1'b1;
                end
                S_DOT_WT:
                    if (alu_done)
                        c_reg <= c_reg + IW'(1);
                S_EMIT:
                    if (out_ld)
                        r_reg <= r_reg + IW'(1);
                S_CLEAR:
                begin
                    gvld_reg <= '0;
                    ivld_reg <= '0;
                    sing_reg <= 1'b0;
                    msel_reg <= 1'b0;
                    for (int k = 0; k < COLS; k++)
                        cross_reg[k] <= '0;
                end
                default:
                begin
                    msel_reg <= msel_reg;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            out_coef_reg <= acc_reg;
            out_idx_reg  <= 3'(r_reg);
            out_last_reg <= (r_reg == LAST);
            out_sing_reg <= sing_reg;
        end

        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    if (epos_reg == PW'(COLS))
                        tgt_reg <= samples.sample;
                    else
                        rb_reg[epos_reg[IW-1:0]] <= samples.sample;
                end
            S_ACC_XR:
                xr_reg <= rb_q;
            S_INV_INIT:
                for (int k = 0; k < COLS; k++)
                    perm_reg[k] <= IW'(k);
            S_PIV_CMP:
                if (j_reg == i_reg || piv_mag > best_mag_reg)
                begin
                    best_mag_reg <= piv_mag;
                    best_val_reg <= gram_eff;
                    piv_reg      <= j_reg;
                end
            S_PIV_SEL:
            begin
                pi_reg  <= perm_q;
                acc_reg <= '0;
            end
            S_SWAP:
            begin
                perm_reg[piv_reg] <= perm_q;
                perm_reg[i_reg]   <= pi_reg;
            end
            S_ELM_J:
                pj_reg <= perm_q;
            S_ELM_FLT:
                f_reg <= gram_eff;
            S_OUT_R:
            begin
                pj_reg  <= perm_q;
                acc_reg <= '0;
            end
            S_DOT_WT:
                if (alu_done)
                    acc_reg <= nels_pkg::sat_addsub(acc_reg, alu_rsp.res, 1'b0);
            default:
            begin
                f_reg <= f_reg;
            end
        endcase
    end

    assign coefs.valid       = ov_reg;
    assign coefs.coefficient = out_coef_reg;
    assign coefs.coef_index  = out_idx_reg;
    assign coefs.last_coef   = out_last_reg;
    assign coefs.singular    = out_sing_reg;

    // Checks
    a_epos_range: assert property (@(posedge clk) disable iff (!rst_n)
        epos_reg <= PW'(COLS))
        else $error("element position past row end");

    a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit started while busy");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ld && sing_reg) |-> (acc_reg == '0))
        else $error("nonzero weight on singular solve");

    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ld && r_reg == LAST) |=> (state_reg == S_CLEAR))
        else $error("accumulators not cleared after last weight");

endmodule

`default_nettype wire
